/* hdl/cfp_pkg.sv */
// Shared types, widths and helpers for the camera frustum point cull block.
// No dependencies; every other file imports this package.
`default_nettype none

package cfp_pkg;

    localparam int COORD_BITS = 20;                  // signed Q11.8 coordinates
    localparam int ENT_BITS   = 20;                  // packed register entry width
    localparam int NORM_BITS  = 16;                  // signed Q1.14 normal
    localparam int DIST_BITS  = 20;                  // unsigned Q12.8 distance
    localparam int Q_BITS     = 32;                  // Q16.16 intrinsics
    localparam int PIX_BITS   = 16;
    localparam int ROT_FRAC   = 18;

    localparam int RP_W   = ENT_BITS + COORD_BITS;   // rotation x point
    localparam int PC_W   = RP_W + 2;                // camera coordinate
    localparam int D_W    = COORD_BITS + 1;          // point minus center
    localparam int DN_W   = D_W + NORM_BITS;         // d x n
    localparam int DOT_W  = DN_W + 1;                // sum of three d x n
    localparam int D2_W   = 2 * D_W;                 // sum of three d^2
    localparam int MM_W   = 2 * DIST_BITS;           // squared range limit
    localparam int SPLIT  = 21;                      // low part of a camera coordinate
    localparam int HI_W   = PC_W - SPLIT;
    localparam int PL_W   = Q_BITS + SPLIT;          // intrinsic x low part
    localparam int PH_W   = Q_BITS + 1 + HI_W;       // intrinsic x high part
    localparam int WIDE_W = PL_W + 23;               // projection sums
    localparam int DLO_W  = 19;                      // low part of the dot product
    localparam int DHI_W  = DOT_W - 1 - DLO_W;
    localparam int CMP_W  = 78;                      // cosine compare width

    typedef enum logic [2:0] {
        CFG_ROT0, CFG_ROT1, CFG_ROT2, CFG_TRANS,
        CFG_CENTER, CFG_FOCAL, CFG_PRINCIPAL, CFG_SIZE
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
        logic [DIST_BITS-1:0]         min_view_distance;
        logic [DIST_BITS-1:0]         max_view_distance;
        logic signed [NORM_BITS-1:0]  normal_x;
        logic signed [NORM_BITS-1:0]  normal_y;
        logic signed [NORM_BITS-1:0]  normal_z;
    } t_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] seen_x;
        logic signed [COORD_BITS-1:0] seen_y;
        logic signed [COORD_BITS-1:0] seen_z;
    } t_out;

    typedef struct packed {
        logic [2:0][2:0][ENT_BITS-1:0] rot;
        logic [2:0][ENT_BITS-1:0]      trans;
        logic [2:0][ENT_BITS-1:0]      center;
        logic [Q_BITS-1:0]             fx;
        logic [Q_BITS-1:0]             fy;
        logic [Q_BITS-1:0]             cx;
        logic [Q_BITS-1:0]             cy;
        logic [PIX_BITS-1:0]           width;
        logic [PIX_BITS-1:0]           height;
    } t_cfg;

    // transform stage result handed to the test stages
    typedef struct packed {
        logic                   valid;
        t_out                   pt;
        logic signed [PC_W-1:0] pc_x;
        logic signed [PC_W-1:0] pc_y;
        logic signed [PC_W-1:0] pc_z;
        logic [D2_W-1:0]        d2;
        logic signed [DOT_W-1:0] dot;
        logic [MM_W-1:0]        mn2;
        logic [MM_W-1:0]        mx2;
    } t_xf;

    // last test stage: point, and whether it survives
    typedef struct packed {
        logic valid;
        logic keep;
        t_out pt;
    } t_verdict;

    // rebuild hi * 2^SPLIT + lo at full width
    function automatic logic signed [WIDE_W-1:0] join_parts(
        logic signed [PH_W-1:0] hi,
        logic [PL_W-1:0]        lo
    );
        join_parts = $signed({{(WIDE_W-PH_W-SPLIT){hi[PH_W-1]}}, hi, {SPLIT{1'b0}}})
                   + $signed({{(WIDE_W-PL_W){1'b0}}, lo});
    endfunction

endpackage

`default_nettype wire

/* hdl/cfp_cfg_regs.sv */
// Configuration register file of the frustum cull block.
// Depends on cfp_pkg for the register index codes and the t_cfg bundle.
`default_nettype none

module cfp_cfg_regs (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr,
    input  wire logic [2:0]            i_index,
    input  wire logic [63:0]           i_data,
    output cfp_pkg::t_cfg              o_cfg
);
    import cfp_pkg::*;

    logic [59:0] r_rot0, r_rot1, r_rot2, r_trans, r_center;
    logic [63:0] r_focal, r_principal;
    logic [31:0] r_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot0      <= 60'd262144;
            r_rot1      <= 60'd274877906944;
            r_rot2      <= 60'd288230376151711744;
            r_trans     <= '0;
            r_center    <= '0;
            r_focal     <= '0;
            r_principal <= '0;
            r_size      <= 32'd31457920;
        end else if (i_wr) begin
            unique case (t_cfg_idx'(i_index))
                CFG_ROT0:      r_rot0      <= i_data[59:0];
                CFG_ROT1:      r_rot1      <= i_data[59:0];
                CFG_ROT2:      r_rot2      <= i_data[59:0];
                CFG_TRANS:     r_trans     <= i_data[59:0];
                CFG_CENTER:    r_center    <= i_data[59:0];
                CFG_FOCAL:     r_focal     <= i_data;
                CFG_PRINCIPAL: r_principal <= i_data;
                CFG_SIZE:      r_size      <= i_data[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.rot    = {r_rot2, r_rot1, r_rot0};
        o_cfg.trans  = r_trans;
        o_cfg.center = r_center;
        o_cfg.fx     = r_focal[31:0];
        o_cfg.fy     = r_focal[63:32];
        o_cfg.cx     = r_principal[31:0];
        o_cfg.cy     = r_principal[63:32];
        o_cfg.width  = r_size[15:0];
        o_cfg.height = r_size[31:16];
    end

endmodule

`default_nettype wire

/* hdl/cfp_xform.sv */
// Stages 1-2: rotation products, center offset, dot and squared distance.
// Depends on cfp_pkg.
`default_nettype none

module cfp_xform (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_valid,
    input  wire cfp_pkg::t_in  i_data,
    input  wire cfp_pkg::t_cfg i_cfg,
    output cfp_pkg::t_xf  o_xf
);
    import cfp_pkg::*;

    logic signed [COORD_BITS-1:0] p [3];
    logic signed [NORM_BITS-1:0]  nrm [3];
    logic signed [D_W-1:0]        d [3];

    logic signed [RP_W-1:0] n1_rp [3][3];
    logic signed [DN_W-1:0] n1_dn [3];
    logic [D2_W-1:0]        n1_dd [3];

    logic                   r1_valid;
    t_out                   r1_pt;
    logic signed [RP_W-1:0] r1_rp [3][3];
    logic signed [DN_W-1:0] r1_dn [3];
    logic [D2_W-1:0]        r1_dd [3];
    logic [MM_W-1:0]        r1_mn2, r1_mx2;

    logic signed [PC_W-1:0] n2_pc [3];

    always_comb begin
        p[0]   = i_data.point_x;
        p[1]   = i_data.point_y;
        p[2]   = i_data.point_z;
        nrm[0] = i_data.normal_x;
        nrm[1] = i_data.normal_y;
        nrm[2] = i_data.normal_z;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n1_rp[i][j] = RP_W'($signed(i_cfg.rot[i][j])) * RP_W'(p[j]);
            end
            d[i]     = D_W'(p[i]) - D_W'($signed(i_cfg.center[i]));
            n1_dn[i] = DN_W'(d[i]) * DN_W'(nrm[i]);
            n1_dd[i] = D2_W'(D2_W'(d[i]) * D2_W'(d[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pt  <= {i_data.point_x, i_data.point_y, i_data.point_z};
            r1_rp  <= n1_rp;
            r1_dn  <= n1_dn;
            r1_dd  <= n1_dd;
            r1_mn2 <= MM_W'(i_data.min_view_distance) * MM_W'(i_data.min_view_distance);
            r1_mx2 <= MM_W'(i_data.max_view_distance) * MM_W'(i_data.max_view_distance);
        end
    end

    // camera coordinates at scale 2^(ROT_FRAC + coordinate fraction)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_pc[i] = PC_W'(r1_rp[i][0]) + PC_W'(r1_rp[i][1]) + PC_W'(r1_rp[i][2])
                     + (PC_W'($signed(i_cfg.trans[i])) <<< ROT_FRAC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_xf.valid <= 1'b0;
        end else if (i_en) begin
            o_xf.valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_xf.pt   <= r1_pt;
            o_xf.pc_x <= n2_pc[0];
            o_xf.pc_y <= n2_pc[1];
            o_xf.pc_z <= n2_pc[2];
            o_xf.d2   <= r1_dd[0] + r1_dd[1] + r1_dd[2];
            o_xf.dot  <= DOT_W'(r1_dn[0]) + DOT_W'(r1_dn[1]) + DOT_W'(r1_dn[2]);
            o_xf.mn2  <= r1_mn2;
            o_xf.mx2  <= r1_mx2;
        end
    end

endmodule

`default_nettype wire

/* hdl/cfp_test.sv */
// Stages 3-4: projection partial products, sums, and the visibility verdict.
// Depends on cfp_pkg.
`default_nettype none

module cfp_test (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire cfp_pkg::t_xf  i_xf,
    input  wire cfp_pkg::t_cfg i_cfg,
    output cfp_pkg::t_verdict o_verdict
);
    import cfp_pkg::*;

    logic signed [PC_W-1:0] pcn [2];
    logic [Q_BITS-1:0]      fq [2];
    logic [Q_BITS-1:0]      cq [2];
    logic [Q_BITS-1:0]      lq [2];
    logic [SPLIT-1:0]       z_lo;
    logic signed [HI_W-1:0] z_hi;
    logic [SPLIT-1:0]       a_lo [2];
    logic signed [HI_W-1:0] a_hi [2];
    logic [DHI_W-1:0]       dot_hi;
    logic [DLO_W-1:0]       dot_lo;

    logic                   r3_valid, r3_ok;
    t_out                   r3_pt;
    logic [PL_W-1:0]        r3_f_lo [2], r3_c_lo [2], r3_t_lo [2];
    logic signed [PH_W-1:0] r3_f_hi [2], r3_c_hi [2], r3_t_hi [2];
    logic [2*DHI_W-1:0]     r3_hh;
    logic [DHI_W+DLO_W-1:0] r3_hl;
    logic [2*DLO_W-1:0]     r3_ll;
    logic [D2_W-1:0]        r3_d2;

    logic                    r4_valid, r4_ok;
    t_out                    r4_pt;
    logic signed [WIDE_W-1:0] r4_s [2], r4_top [2];
    logic [CMP_W-1:0]        r4_dot4, r4_d2s;

    always_comb begin
        pcn[0] = i_xf.pc_x;
        pcn[1] = i_xf.pc_y;
        fq[0]  = i_cfg.fx;
        fq[1]  = i_cfg.fy;
        cq[0]  = i_cfg.cx;
        cq[1]  = i_cfg.cy;
        lq[0]  = {i_cfg.width, 16'b0};
        lq[1]  = {i_cfg.height, 16'b0};
        z_lo   = i_xf.pc_z[SPLIT-1:0];
        z_hi   = i_xf.pc_z[PC_W-1:SPLIT];
        for (int a = 0; a < 2; a++) begin
            a_lo[a] = pcn[a][SPLIT-1:0];
            a_hi[a] = pcn[a][PC_W-1:SPLIT];
        end
        dot_hi = i_xf.dot[DOT_W-2:DLO_W];
        dot_lo = i_xf.dot[DLO_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= i_xf.valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_pt <= i_xf.pt;
            // drop on depth at or behind the camera, distance out of range, or facing away
            r3_ok <= (i_xf.pc_z > 0) && !(i_xf.d2 < D2_W'(i_xf.mn2))
                     && !(D2_W'(i_xf.mx2) < i_xf.d2) && !i_xf.dot[DOT_W-1];
            for (int a = 0; a < 2; a++) begin
                r3_f_lo[a] <= PL_W'(fq[a]) * PL_W'(a_lo[a]);
                r3_f_hi[a] <= PH_W'($signed({1'b0, fq[a]})) * PH_W'(a_hi[a]);
                r3_c_lo[a] <= PL_W'(cq[a]) * PL_W'(z_lo);
                r3_c_hi[a] <= PH_W'($signed({1'b0, cq[a]})) * PH_W'(z_hi);
                r3_t_lo[a] <= PL_W'(lq[a]) * PL_W'(z_lo);
                r3_t_hi[a] <= PH_W'($signed({1'b0, lq[a]})) * PH_W'(z_hi);
            end
            r3_hh <= (2*DHI_W)'(dot_hi) * (2*DHI_W)'(dot_hi);
            r3_hl <= (DHI_W+DLO_W)'(dot_hi) * (DHI_W+DLO_W)'(dot_lo);
            r3_ll <= (2*DLO_W)'(dot_lo) * (2*DLO_W)'(dot_lo);
            r3_d2 <= i_xf.d2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_pt <= r3_pt;
            r4_ok <= r3_ok;
            for (int a = 0; a < 2; a++) begin
                r4_s[a]   <= join_parts(r3_f_hi[a], r3_f_lo[a])
                           + join_parts(r3_c_hi[a], r3_c_lo[a]);
                r4_top[a] <= join_parts(r3_t_hi[a], r3_t_lo[a]);
            end
            // 4*dot^2 against 2^28*|d|^2
            r4_dot4 <= ((CMP_W'(r3_hh) << (2*DLO_W)) + (CMP_W'(r3_hl) << (DLO_W+1))
                       + CMP_W'(r3_ll)) << 2;
            r4_d2s  <= CMP_W'(r3_d2) << 28;
        end
    end

    always_comb begin
        o_verdict.valid = r4_valid;
        o_verdict.pt    = r4_pt;
        o_verdict.keep  = r4_ok && !(r4_dot4 < r4_d2s);
        for (int a = 0; a < 2; a++) begin
            if (r4_s[a] < 0 || r4_top[a] < r4_s[a]) begin
                o_verdict.keep = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/camera_frustum_point_cull.sv */
// Top level of the camera frustum point cull: config registers, pipeline, output register.
// Depends on cfp_pkg, cfp_cfg_regs, cfp_xform and cfp_test.
`default_nettype none

// Takes one map point per cycle and passes it on unchanged only when it lies in
// front of the camera, projects inside the image (borders included), sits within
// its own viewing-distance range and is seen at a cosine of at least one half.
// A request passes through two stages of transform and distance math, two
// stages of projection products and sums, and then the output
// register. Throughput is one request per cycle; a stall on the output freezes
// the whole pipeline. Configuration writes are always ready and must be made
// while no request is in flight.
module camera_frustum_point_cull (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output      logic           o_in_stall,
    input  wire cfp_pkg::t_in   i_in_data,
    output      logic           o_out_valid,
    input  wire logic           i_out_stall,
    output cfp_pkg::t_out       o_out_data,
    input  wire logic           i_cfg_valid,
    output      logic           o_cfg_ready,
    input  wire logic [2:0]     i_cfg_index,
    input  wire logic [63:0]    i_cfg_data
);
    import cfp_pkg::*;

    t_cfg     cfg;
    t_xf      xf;
    t_verdict verdict;
    logic     en;
    logic     r_out_valid;
    t_out     r_out_data;

    // advance everything unless a held result is stalled
    assign en          = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    cfp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    cfp_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_cfg   (cfg),
        .o_xf    (xf)
    );

    cfp_test u_test (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_xf      (xf),
        .i_cfg     (cfg),
        .o_verdict (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= verdict.valid && verdict.keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= verdict.pt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for camera_frustum_point_cull: point requests are predicted
// with exact integer math and compared against the visible points that come out.
// Depends on cfp_pkg and the camera_frustum_point_cull RTL.
`default_nettype none

module tb_top;
    import cfp_pkg::*;

    localparam int LATENCY   = 5;
    localparam int RAND_REQ  = 1300;
    localparam int WDOG_MAX  = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    camera_frustum_point_cull DUT (.*);

    always #1 i_clk = ~i_clk;

    // predictor copy of the registers
    logic [63:0] cam_reg [8];
    t_out        seen_q [$];
    int          mismatches = 0;
    int          seen_cnt = 0;
    int          sent_cnt = 0;
    int          idle_pct = 32;
    bit          hold_off = 0;
    int          wdog = 0;

    function automatic longint ent(logic [63:0] r, int j);
        logic [19:0] e;
        e = r[20*j +: 20];
        return longint'($signed(e));
    endfunction

    function automatic bit in_frame(longint f, longint c, longint lim,
                                    logic signed [127:0] num, logic signed [127:0] den);
        logic signed [127:0] s, top;
        s   = 128'(f) * num + 128'(c) * den;
        top = (128'(lim) <<< 16) * den;
        return s >= 0 && top >= s;
    endfunction

    function automatic bit is_visible(t_in p);
        logic signed [127:0] pt [3], pc [3], d [3], d2, dot, mn, mx;
        pt[0] = 128'(p.point_x); pt[1] = 128'(p.point_y); pt[2] = 128'(p.point_z);
        d2 = '0; dot = '0;
        for (int i = 0; i < 3; i++) begin
            pc[i] = 128'(ent(cam_reg[CFG_TRANS], i)) <<< 18;
            for (int j = 0; j < 3; j++)
                pc[i] += 128'(ent(cam_reg[i], j)) * pt[j];
        end
        if (pc[2] <= 0) return 0;
        if (!in_frame(longint'(cam_reg[CFG_FOCAL][31:0]),
                      longint'(cam_reg[CFG_PRINCIPAL][31:0]),
                      longint'(cam_reg[CFG_SIZE][15:0]), pc[0], pc[2])) return 0;
        if (!in_frame(longint'(cam_reg[CFG_FOCAL][63:32]),
                      longint'(cam_reg[CFG_PRINCIPAL][63:32]),
                      longint'(cam_reg[CFG_SIZE][31:16]), pc[1], pc[2])) return 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = pt[i] - 128'(ent(cam_reg[CFG_CENTER], i));
            d2 += d[i] * d[i];
        end
        dot = d[0] * 128'(p.normal_x) + d[1] * 128'(p.normal_y) + d[2] * 128'(p.normal_z);
        mn = 128'(p.min_view_distance);
        mx = 128'(p.max_view_distance);
        // distances are squared at the coordinate scale; dot carries 2^14 more
        if (d2 < mn * mn) return 0;
        if (mx * mx < d2) return 0;
        if (dot < 0) return 0;
        if (((dot * dot) <<< 2) < (d2 <<< 28)) return 0;
        return 1;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx) inside
            CFG_FOCAL, CFG_PRINCIPAL: cam_reg[idx] = val;
            CFG_SIZE:                 cam_reg[idx] = {32'b0, val[31:0]};
            default:                  cam_reg[idx] = {4'b0, val[59:0]};
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain;
        while (seen_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 3) @(posedge i_clk);
    endtask

    // send one request; gold_vis < 0 means use the predictor
    task automatic send_point(t_in p, int gold_vis);
        bit   vis;
        t_out exp_pt;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        vis = is_visible(p);
        if (gold_vis >= 0 && vis != gold_vis[0]) begin
            mismatches++;
            if (mismatches <= 10)
                $display("directed row: predictor visible=%0d, expected %0d", vis, gold_vis);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        exp_pt = {p.point_x, p.point_y, p.point_z};
        if (vis) seen_q.insert(seen_q.size(), exp_pt);
        sent_cnt++;
    endtask

    // result side
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (seen_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point %h", o_out_data);
            end else begin
                t_out e;
                e = seen_q.pop_front();
                seen_cnt++;
                if (e.seen_x !== o_out_data.seen_x || e.seen_y !== o_out_data.seen_y
                    || e.seen_z !== o_out_data.seen_z) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("point mismatch: expected %h got %h", e, o_out_data);
                end
            end
        end
        i_out_stall <= hold_off || ($urandom_range(99) < idle_pct);
    end

    // watchdog on accepted traffic
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog > WDOG_MAX) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_in rand_point(bit near);
        t_in p;
        p = '0;
        p.point_x = 20'($urandom);
        p.point_y = 20'($urandom);
        p.point_z = 20'($urandom);
        p.min_view_distance = 20'($urandom);
        p.max_view_distance = 20'($urandom);
        p.normal_x = 16'($urandom);
        p.normal_y = 16'($urandom);
        p.normal_z = 16'($urandom);
        if (near) begin
            // aim at the frustum: small x/y, positive z, normal toward camera
            p.point_x = 20'(int'($urandom_range(8000)) - 4000);
            p.point_y = 20'(int'($urandom_range(8000)) - 4000);
            p.point_z = 20'($urandom_range(60000, 256));
            p.normal_x = -16'sd4000 + 16'($urandom_range(8000));
            p.normal_y = -16'sd4000 + 16'($urandom_range(8000));
            p.normal_z = 16'($urandom_range(32767, 12000));
            p.min_view_distance = 20'($urandom_range(255));
            p.max_view_distance = $urandom_range(3) == 0 ? 20'($urandom)
                                                         : 20'($urandom_range(1048575, 70000));
        end
        return p;
    endfunction

    typedef struct {
        t_in p;
        int  vis;
    } t_row;

    t_row rows [$];

    function automatic void add_row(t_in p, int vis);
        t_row r;
        r.p   = p;
        r.vis = vis;
        rows.insert(rows.size(), r);
    endfunction

    initial begin
        t_in  p;
        cam_reg[0] = 64'd262144;
        cam_reg[1] = 64'd274877906944;
        cam_reg[2] = 64'd288230376151711744;
        cam_reg[3] = '0; cam_reg[4] = '0; cam_reg[5] = '0; cam_reg[6] = '0;
        cam_reg[7] = 64'd31457920;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset camera: zero intrinsics project to u=v=0, on the border
        p = '0; p.point_z = 20'sd256; p.max_view_distance = 20'hFFFFF; p.normal_z = 16'sd16384;
        add_row(p, 1);
        p.point_z = '0;                      add_row(p, 0); // depth zero is dropped
        p.point_z = -20'sd256;               add_row(p, 0); // behind camera
        p.point_z = 20'sd256; p.max_view_distance = '0;  add_row(p, 0);
        p.max_view_distance = 20'hFFFFF; p.min_view_distance = 20'hFFFFF;
        add_row(p, 0);                                     // closer than the minimum
        p.min_view_distance = '0; p.normal_z = -16'sd16384; add_row(p, 0);
        p.normal_z = 16'sh7FFF; p.point_x = 20'sh7FFFF; p.point_z = 20'sh7FFFF;
        add_row(p, -1);
        p.point_x = -20'sh80000; p.point_y = -20'sh80000; p.normal_x = -16'sh8000;
        p.normal_y = -16'sh8000; add_row(p, -1);
        foreach (rows[i]) send_point(rows[i].p, rows[i].vis);
        i_in_valid <= 1'b0;
        drain();

        // realistic camera: fx=fy=500, centre (320,240), default identity
        write_reg(CFG_FOCAL, {32'd500 << 16, 32'd500 << 16});
        write_reg(CFG_PRINCIPAL, {32'd240 << 16, 32'd320 << 16});
        write_reg(CFG_SIZE, 64'd31457920);
        for (int i = 0; i < 12; i++) send_point(rand_point(1), -1);
        i_in_valid <= 1'b0;
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 5) begin
                // extremes on every register
                for (int r = 0; r < 8; r++)
                    write_reg(t_cfg_idx'(r), 64'hFFFF_FFFF_FFFF_FFFF);
            end else if (phase > 0) begin
                write_reg(CFG_ROT0, {40'($urandom_range(3000)) << 20,
                                     20'($urandom_range(270000, 250000))});
                write_reg(CFG_ROT1, {20'd0, 20'($urandom_range(270000, 250000)),
                                     20'($urandom_range(3000))});
                write_reg(CFG_ROT2, {20'($urandom_range(270000, 250000)), 40'd0});
                write_reg(CFG_TRANS, {20'($urandom_range(5000)), 20'($urandom),
                                      20'($urandom)} & 60'h0003F_0003F_FFFFF);
                write_reg(CFG_CENTER, {$urandom, $urandom});
                write_reg(CFG_FOCAL, {32'($urandom_range(2000)) << 16, $urandom});
                write_reg(CFG_PRINCIPAL, {$urandom, $urandom});
                write_reg(CFG_SIZE, phase == 4 ? 64'd0 : 64'($urandom));
            end
            idle_pct = (phase == 2) ? 0 : 32;
            if (phase == 3) fork
                begin
                    hold_off = 1;
                    repeat (60) @(posedge i_clk);
                    hold_off = 0;
                end
            join_none
            for (int i = 0; i < RAND_REQ / 6; i++)
                send_point(rand_point($urandom_range(99) < 80), -1);
            i_in_valid <= 1'b0;
            drain();
        end

        $display("Sent %0d point requests across 7 camera setups; %0d came out visible.",
                 sent_cnt, seen_cnt);
        if (mismatches == 0 && seen_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

`default_nettype wire
